[rtl/pgg_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pgg_pkg: shared types and constants of the polar Gaussian generator
// Fixed-point constants, stage counts and the register index codes.
// ----------------------------------------------------------------------------
package pgg_pkg;

  // Number of squaring rounds of the log2 unit (fraction bits of the log).
  localparam int LOG_ROUNDS = 28;
  // Quotient bits of the v^2 / D division (one integer bit plus Q28).
  localparam int Q_BITS = LOG_ROUNDS + 1;
  // Result bits of the square root, one per stage.
  localparam int ROOT_STEPS = 32;

  // 2 ln 2 in Q28.
  localparam logic [28:0] TWO_LN2_Q28 = 29'd372130559;
  // One half in Q28, used for round half up.
  localparam logic [62:0] HALF_Q28 = 63'd134217728;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_MEAN  = 1'b0,
    REG_WIDTH = 1'b1
  } cfg_reg_t;

  // Signs of the two centered samples, carried down the pipeline.
  typedef struct packed {
    logic neg_a;
    logic neg_b;
  } sign_t;

endpackage
`default_nettype wire

[rtl/pgg_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pgg_front: centering, squaring, radius test and leading-one search
// Four stages: |v| per sample, v^2, D = va^2 + vb^2 with rejection, and the
// position of the top set bit of D.
// ----------------------------------------------------------------------------
module pgg_front #(
  parameter int UNIFORM_BITS = 32
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           adv,
  input  wire logic           in_valid,
  input  wire logic [31:0]    uniform_a,
  input  wire logic [31:0]    uniform_b,
  output logic                out_valid,
  output logic [61:0]         den,
  output logic [61:0]         num_a,
  output logic [61:0]         num_b,
  output logic [5:0]          lead,
  output pgg_pkg::sign_t      signs
);
  import pgg_pkg::*;

  localparam int SHR = (UNIFORM_BITS >= 32) ? UNIFORM_BITS - 32 : 0;
  localparam int SHL = (UNIFORM_BITS < 32) ? 32 - UNIFORM_BITS : 0;
  localparam logic [63:0] MASK = (64'd1 << UNIFORM_BITS) - 64'd1;

  logic [31:0] frac_a, frac_b;
  logic [31:0] abs_a, abs_b;
  logic [31:0] aa1, ab1;
  sign_t       sg1, sg2, sg3;
  logic [63:0] sq_a, sq_b;
  logic [63:0] sqa2, sqb2;
  logic [63:0] sum;
  logic        keep;
  logic [61:0] den3, na3, nb3;
  logic [5:0]  lead_c;
  logic        v1, v2, v3;

  // Take the samples to 32-bit fractions and center them around one half.
  assign frac_a = 32'(((({32'b0, uniform_a}) & MASK) >> SHR) << SHL);
  assign frac_b = 32'(((({32'b0, uniform_b}) & MASK) >> SHR) << SHL);
  assign abs_a  = frac_a[31] ? {1'b0, frac_a[30:0]} : 32'h8000_0000 - frac_a;
  assign abs_b  = frac_b[31] ? {1'b0, frac_b[30:0]} : 32'h8000_0000 - frac_b;

  // Squares of the magnitudes.
  assign sq_a = aa1 * aa1;
  assign sq_b = ab1 * ab1;

  // Squared radius; zero and values of one or more are rejected.
  assign sum  = sqa2 + sqb2;
  assign keep = (sum != 64'd0) && (sum[63:62] == 2'b00);

  // Position of the top set bit of the radius.
  always_comb begin
    lead_c = '0;
    for (int i = 0; i < 62; i++) begin
      if (den3[i]) begin
        lead_c = 6'(i);
      end
    end
  end

  // Valid bits of the four stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2 && keep;
      out_valid <= v3;
    end
  end

  // Data of the four stages.
  always_ff @(posedge clk) begin
    if (adv) begin
      aa1       <= abs_a;
      ab1       <= abs_b;
      sg1.neg_a <= ~frac_a[31];
      sg1.neg_b <= ~frac_b[31];
      sqa2      <= sq_a;
      sqb2      <= sq_b;
      sg2       <= sg1;
      den3      <= sum[61:0];
      na3       <= sqa2[61:0];
      nb3       <= sqb2[61:0];
      sg3       <= sg2;
      den       <= den3;
      num_a     <= na3;
      num_b     <= nb3;
      lead      <= lead_c;
      signs     <= sg3;
    end
  end

endmodule
`default_nettype wire

[rtl/pgg_logdiv.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pgg_logdiv: log2 by repeated squaring beside two restoring dividers
// One normalizing stage, then one squaring round of the log and one
// quotient bit of each division in every stage.
// ----------------------------------------------------------------------------
module pgg_logdiv (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        adv,
  input  wire logic                        in_valid,
  input  wire logic [61:0]                 den,
  input  wire logic [61:0]                 num_a,
  input  wire logic [61:0]                 num_b,
  input  wire logic [5:0]                  lead,
  input  wire pgg_pkg::sign_t              signs,
  output logic                             out_valid,
  output logic [5:0]                       out_lead,
  output logic [pgg_pkg::LOG_ROUNDS-1:0]   frac,
  output logic [pgg_pkg::Q_BITS-1:0]       quo_a,
  output logic [pgg_pkg::Q_BITS-1:0]       quo_b,
  output pgg_pkg::sign_t                   out_signs
);
  import pgg_pkg::*;

  logic [LOG_ROUNDS:0] vld;
  logic [31:0]         m    [0:LOG_ROUNDS];
  logic [LOG_ROUNDS-1:0] fr [0:LOG_ROUNDS];
  logic [Q_BITS-1:0]   qa   [0:LOG_ROUNDS];
  logic [Q_BITS-1:0]   qb   [0:LOG_ROUNDS];
  logic [61:0]         ra   [0:LOG_ROUNDS];
  logic [61:0]         rb   [0:LOG_ROUNDS];
  logic [61:0]         dn   [0:LOG_ROUNDS];
  logic [5:0]          ld   [0:LOG_ROUNDS];
  sign_t               sg   [0:LOG_ROUNDS];

  logic [5:0]  rsh, lsh;
  logic [31:0] m_init;
  logic        ge_a0, ge_b0;

  // Normalize the radius to a mantissa in [1,2) with 31 fraction bits.
  assign rsh    = lead - 6'd31;
  assign lsh    = 6'd31 - lead;
  assign m_init = (lead >= 6'd31) ? 32'(den >> rsh) : 32'(den << lsh);

  // Integer bit of each quotient.
  assign ge_a0 = num_a >= den;
  assign ge_b0 = num_b >= den;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m[0]  <= m_init;
      fr[0] <= '0;
      qa[0] <= Q_BITS'(ge_a0);
      qb[0] <= Q_BITS'(ge_b0);
      ra[0] <= ge_a0 ? num_a - den : num_a;
      rb[0] <= ge_b0 ? num_b - den : num_b;
      dn[0] <= den;
      ld[0] <= lead;
      sg[0] <= signs;
    end
  end

  // One log round and one quotient bit per stage.
  for (genvar k = 0; k < LOG_ROUNDS; k++) begin : g_round
    logic [63:0] sq;
    logic [32:0] sh;
    logic [31:0] mn;
    logic [62:0] ta, tb, dd;
    logic        ga, gb;

    assign sq = m[k] * m[k];
    assign sh = sq[63:31];
    assign mn = sh[32] ? sh[32:1] : sh[31:0];
    assign ta = {ra[k], 1'b0};
    assign tb = {rb[k], 1'b0};
    assign dd = {1'b0, dn[k]};
    assign ga = ta >= dd;
    assign gb = tb >= dd;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (adv) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        m[k+1]  <= mn;
        fr[k+1] <= {fr[k][LOG_ROUNDS-2:0], sh[32]};
        qa[k+1] <= {qa[k][Q_BITS-2:0], ga};
        qb[k+1] <= {qb[k][Q_BITS-2:0], gb};
        ra[k+1] <= ga ? 62'(ta - dd) : ta[61:0];
        rb[k+1] <= gb ? 62'(tb - dd) : tb[61:0];
        dn[k+1] <= dn[k];
        ld[k+1] <= ld[k];
        sg[k+1] <= sg[k];
      end
    end
  end

  assign out_valid = vld[LOG_ROUNDS];
  assign out_lead  = ld[LOG_ROUNDS];
  assign frac      = fr[LOG_ROUNDS];
  assign quo_a     = qa[LOG_ROUNDS];
  assign quo_b     = qb[LOG_ROUNDS];
  assign out_signs = sg[LOG_ROUNDS];

`ifndef NO_ASSERTIONS
  // The mantissa is still normalized after the last squaring round.
  a_norm: assert property (@(posedge clk) disable iff (rst)
    vld[LOG_ROUNDS] |-> m[LOG_ROUNDS][31])
    else $error("log mantissa lost its top bit");

  // Remainders stay below the divisor.
  a_rem: assert property (@(posedge clk) disable iff (rst)
    vld[LOG_ROUNDS] |-> (ra[LOG_ROUNDS] < dn[LOG_ROUNDS] && rb[LOG_ROUNDS] < dn[LOG_ROUNDS]))
    else $error("division remainder not below divisor");

  // A quotient never exceeds one.
  a_quo: assert property (@(posedge clk) disable iff (rst)
    vld[LOG_ROUNDS] |-> ((!quo_a[Q_BITS-1] || quo_a[Q_BITS-2:0] == '0) &&
                         (!quo_b[Q_BITS-1] || quo_b[Q_BITS-2:0] == '0)))
    else $error("division quotient above one");

  // A zero radius never enters the log unit.
  a_den: assert property (@(posedge clk) disable iff (rst)
    vld[0] |-> (dn[0] != 62'd0))
    else $error("zero radius entered the log unit");
`endif

endmodule
`default_nettype wire

[rtl/pgg_root.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pgg_root: log scaling and square root
// Forms S = -2 ln d, the products t * S, and their integer square roots,
// one result bit per stage.
// ----------------------------------------------------------------------------
module pgg_root (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        adv,
  input  wire logic                        in_valid,
  input  wire logic [5:0]                  lead,
  input  wire logic [pgg_pkg::LOG_ROUNDS-1:0] frac,
  input  wire logic [pgg_pkg::Q_BITS-1:0]  quo_a,
  input  wire logic [pgg_pkg::Q_BITS-1:0]  quo_b,
  input  wire pgg_pkg::sign_t              signs,
  output logic                             out_valid,
  output logic [31:0]                      root_a,
  output logic [31:0]                      root_b,
  output pgg_pkg::sign_t                   out_signs
);
  import pgg_pkg::*;

  // Scaling stages.
  logic [33:0]       lval;
  logic [62:0]       lprod;
  logic [34:0]       sval;
  logic [Q_BITS-1:0] ta1, tb1, ta2, tb2, ta3, tb3;
  logic [46:0]       pla, plb;
  logic [45:0]       pha, phb;
  sign_t             sg1, sg2, sg3, sg4;
  logic              v1, v2, v3, v4;

  // Square root stages.
  logic [ROOT_STEPS:0] vld;
  logic [63:0] xa [0:ROOT_STEPS];
  logic [63:0] xb [0:ROOT_STEPS];
  logic [63:0] ya [0:ROOT_STEPS];
  logic [63:0] yb [0:ROOT_STEPS];
  sign_t       sg [0:ROOT_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1     <= 1'b0;
      v2     <= 1'b0;
      v3     <= 1'b0;
      v4     <= 1'b0;
      vld[0] <= 1'b0;
    end else if (adv) begin
      v1     <= in_valid;
      v2     <= v1;
      v3     <= v2;
      v4     <= v3;
      vld[0] <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // -log2(d) in Q28.
      lval  <= {6'(6'd62 - lead), 28'b0} - {6'b0, frac};
      ta1   <= quo_a;
      tb1   <= quo_b;
      sg1   <= signs;
      // Times 2 ln 2.
      lprod <= lval * TWO_LN2_Q28;
      ta2   <= ta1;
      tb2   <= tb1;
      sg2   <= sg1;
      // Round back to Q28.
      sval  <= 35'((lprod + HALF_Q28) >> 28);
      ta3   <= ta2;
      tb3   <= tb2;
      sg3   <= sg2;
      // Partial products of t * S.
      pla   <= ta3 * sval[17:0];
      pha   <= ta3 * sval[34:18];
      plb   <= tb3 * sval[17:0];
      phb   <= tb3 * sval[34:18];
      sg4   <= sg3;
      // Sum of the partial products.
      xa[0] <= 64'(pla) + (64'(pha) << 18);
      xb[0] <= 64'(plb) + (64'(phb) << 18);
      ya[0] <= '0;
      yb[0] <= '0;
      sg[0] <= sg4;
    end
  end

  // Digit-by-digit square root, one result bit per stage.
  for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_step
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic [63:0] trya, tryb;
    logic        ga, gb;

    assign trya = ya[k] + BIT;
    assign tryb = yb[k] + BIT;
    assign ga   = xa[k] >= trya;
    assign gb   = xb[k] >= tryb;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (adv) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        xa[k+1] <= ga ? xa[k] - trya : xa[k];
        xb[k+1] <= gb ? xb[k] - tryb : xb[k];
        ya[k+1] <= ga ? (ya[k] >> 1) + BIT : ya[k] >> 1;
        yb[k+1] <= gb ? (yb[k] >> 1) + BIT : yb[k] >> 1;
        sg[k+1] <= sg[k];
      end
    end
  end

  assign out_valid = vld[ROOT_STEPS];
  assign root_a    = ya[ROOT_STEPS][31:0];
  assign root_b    = yb[ROOT_STEPS][31:0];
  assign out_signs = sg[ROOT_STEPS];

endmodule
`default_nettype wire

[rtl/pgg_out.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pgg_out: scaling by width, offset by mean and saturation
// Two stages; the second is the output register of the block.
// ----------------------------------------------------------------------------
module pgg_out (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                adv,
  input  wire logic                in_valid,
  input  wire logic [31:0]         root_a,
  input  wire logic [31:0]         root_b,
  input  wire pgg_pkg::sign_t      signs,
  input  wire logic signed [31:0]  mean,
  input  wire logic [30:0]         width,
  output logic                     out_valid,
  output logic signed [31:0]       normal_a,
  output logic signed [31:0]       normal_b
);
  import pgg_pkg::*;

  logic [62:0] pa, pb;
  sign_t       sg1;
  logic        v1;
  logic [34:0] mag_a, mag_b;
  logic signed [37:0] mean_x, sum_a, sum_b;
  logic signed [31:0] sat_a, sat_b;

  // Round the magnitudes and apply them around the mean.
  assign mag_a  = 35'((pa + HALF_Q28) >> 28);
  assign mag_b  = 35'((pb + HALF_Q28) >> 28);
  assign mean_x = 38'(mean);
  assign sum_a  = sg1.neg_a ? mean_x - signed'({3'b0, mag_a}) : mean_x + signed'({3'b0, mag_a});
  assign sum_b  = sg1.neg_b ? mean_x - signed'({3'b0, mag_b}) : mean_x + signed'({3'b0, mag_b});

  // Clamp to the signed 32-bit range.
  always_comb begin
    if (sum_a > 38'sd2147483647) begin
      sat_a = 32'sh7FFF_FFFF;
    end else if (sum_a < -38'sd2147483648) begin
      sat_a = 32'sh8000_0000;
    end else begin
      sat_a = sum_a[31:0];
    end
    if (sum_b > 38'sd2147483647) begin
      sat_b = 32'sh7FFF_FFFF;
    end else if (sum_b < -38'sd2147483648) begin
      sat_b = 32'sh8000_0000;
    end else begin
      sat_b = sum_b[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= in_valid;
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pa       <= width * root_a;
      pb       <= width * root_b;
      sg1      <= signs;
      normal_a <= sat_a;
      normal_b <= sat_b;
    end
  end

endmodule
`default_nettype wire

[rtl/polar_gaussian_generator.sv]
// Throughput: one uniform pair per cycle while no finished word is held at
// the stalled output; most stages are one squaring round, one divider bit or
// one square-root bit, so the depth is set mostly by those units.
// Rejected pairs (zero radius or radius of one or more) produce no word.
// Reset clears all valid bits and loads mean = 200.0 and width = 10.0.
`default_nettype none
// ----------------------------------------------------------------------------
// polar_gaussian_generator: Marsaglia polar method, fully pipelined
// Turns pairs of uniform samples into pairs of normal deviates in signed
// fixed point, with programmable mean and width.
// ----------------------------------------------------------------------------
module polar_gaussian_generator #(
  parameter int UNIFORM_BITS = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [31:0]        uniform_a,
  input  wire logic [31:0]        uniform_b,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      normal_a,
  output logic signed [31:0]      normal_b,
  input  wire logic               wr_en,
  input  wire logic [0:0]         wr_index,
  input  wire logic [31:0]        wr_data
);
  import pgg_pkg::*;

  logic signed [31:0] mean;
  logic [30:0]        width;
  logic               adv;

  logic        f_valid;
  logic [61:0] f_den, f_num_a, f_num_b;
  logic [5:0]  f_lead;
  sign_t       f_signs;

  logic                  l_valid;
  logic [5:0]            l_lead;
  logic [LOG_ROUNDS-1:0] l_frac;
  logic [Q_BITS-1:0]     l_quo_a, l_quo_b;
  sign_t                 l_signs;

  logic        r_valid;
  logic [31:0] r_root_a, r_root_b;
  sign_t       r_signs;

  // The whole pipeline moves unless a finished word is held at the output.
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mean  <= 32'sd13107200;
      width <= 31'd655360;
    end else if (wr_en) begin
      unique case (cfg_reg_t'(wr_index))
        REG_MEAN:  mean  <= wr_data;
        REG_WIDTH: width <= wr_data[30:0];
      endcase
    end
  end

  pgg_front #(.UNIFORM_BITS(UNIFORM_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (in_valid),
    .uniform_a (uniform_a),
    .uniform_b (uniform_b),
    .out_valid (f_valid),
    .den       (f_den),
    .num_a     (f_num_a),
    .num_b     (f_num_b),
    .lead      (f_lead),
    .signs     (f_signs)
  );

  pgg_logdiv u_logdiv (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (f_valid),
    .den       (f_den),
    .num_a     (f_num_a),
    .num_b     (f_num_b),
    .lead      (f_lead),
    .signs     (f_signs),
    .out_valid (l_valid),
    .out_lead  (l_lead),
    .frac      (l_frac),
    .quo_a     (l_quo_a),
    .quo_b     (l_quo_b),
    .out_signs (l_signs)
  );

  pgg_root u_root (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (l_valid),
    .lead      (l_lead),
    .frac      (l_frac),
    .quo_a     (l_quo_a),
    .quo_b     (l_quo_b),
    .signs     (l_signs),
    .out_valid (r_valid),
    .root_a    (r_root_a),
    .root_b    (r_root_b),
    .out_signs (r_signs)
  );

  pgg_out u_out (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (r_valid),
    .root_a    (r_root_a),
    .root_b    (r_root_b),
    .signs     (r_signs),
    .mean      (mean),
    .width     (width),
    .out_valid (out_valid),
    .normal_a  (normal_a),
    .normal_b  (normal_b)
  );

endmodule
`default_nettype wire
